// File: rtl/ral_pkg.sv
// Shared types and codes for the reorder active list.
// No dependencies.
package ral_pkg;
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0, OP_PEEK = 3'd1, OP_POP = 3'd2, OP_UPDATE = 3'd3,
    OP_DEPQ = 3'd4, OP_MDONE = 3'd5, OP_MEXC = 3'd6, OP_NONE = 3'd7
  } op_e;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BADIDX = 2'd2;
  typedef struct packed {
    logic load;
    logic scan;
  } cmd_t;
  typedef struct packed {
    logic busy;
  } sts_t;
endpackage

// File: rtl/reorder_active_list_core.sv
// Top level of the reorder active list: controller plus datapath.
// Uses ral_pkg, ral_ctrl, ral_dp.
// Each operation goes through capture, one parallel pass over all
// entry cells (compare, shift or write), then the result beat; a new item is
// taken once the result is taken. Occupancy follows each operation.
module reorder_active_list_core #(
  parameter int LIST_DEPTH = 32,
  parameter int PC_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] opcode_i,
  input  logic [4:0] position_i,
  input  logic [PC_WIDTH-1:0] entry_pc_i,
  input  logic [4:0] entry_log_dest_i,
  input  logic [5:0] entry_old_phys_i,
  input  logic entry_done_i,
  input  logic entry_exception_i,
  input  logic [4:0] reg_query_i,
  input  logic mark_value_i,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status_o,
  output logic [31:0] out_pc_o,
  output logic [4:0] out_log_dest_o,
  output logic [5:0] out_old_phys_o,
  output logic out_done_o,
  output logic out_exception_o,
  output logic dependent_o,
  output logic [5:0] occupancy_o
);
  import ral_pkg::*;
  cmd_t cmd;
  sts_t sts;

  ral_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
                   .sts_i(sts), .cmd_o(cmd));
  ral_dp #(.LIST_DEPTH(LIST_DEPTH), .PC_WIDTH(PC_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .opcode_i, .position_i, .entry_pc_i,
    .entry_log_dest_i, .entry_old_phys_i, .entry_done_i, .entry_exception_i,
    .reg_query_i, .mark_value_i, .status_o, .out_pc_o, .out_log_dest_o,
    .out_old_phys_o, .out_done_o, .out_exception_o, .dependent_o, .occupancy_o);
endmodule

// File: rtl/ral_ctrl.sv
// Handshake controller of the reorder active list.
// Uses ral_pkg.
module ral_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  ral_pkg::sts_t sts_i,
  output ral_pkg::cmd_t cmd_o
);
  import ral_pkg::*;
  typedef enum logic [1:0] {S_IDLE, S_WORK, S_DONE} state_e;
  state_e state_q;

  assign in_ready  = (state_q == S_IDLE);
  assign out_valid = (state_q == S_DONE);
  always_comb begin
    cmd_o.load = in_valid && in_ready;
    cmd_o.scan = (state_q == S_WORK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid) state_q <= S_WORK;
        S_WORK: if (!sts_i.busy) state_q <= S_DONE;
        S_DONE: if (out_ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/ral_dp.sv
// Datapath of the reorder active list: entry cells, count, result register.
// Uses ral_pkg.
module ral_dp #(
  parameter int LIST_DEPTH = 32,
  parameter int PC_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  ral_pkg::cmd_t cmd_i,
  output ral_pkg::sts_t sts_o,
  input  logic [2:0] opcode_i,
  input  logic [4:0] position_i,
  input  logic [PC_WIDTH-1:0] entry_pc_i,
  input  logic [4:0] entry_log_dest_i,
  input  logic [5:0] entry_old_phys_i,
  input  logic entry_done_i,
  input  logic entry_exception_i,
  input  logic [4:0] reg_query_i,
  input  logic mark_value_i,
  output logic [1:0] status_o,
  output logic [31:0] out_pc_o,
  output logic [4:0] out_log_dest_o,
  output logic [5:0] out_old_phys_o,
  output logic out_done_o,
  output logic out_exception_o,
  output logic dependent_o,
  output logic [5:0] occupancy_o
);
  import ral_pkg::*;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = $clog2(LIST_DEPTH);

  logic [PC_WIDTH-1:0] pc_q [LIST_DEPTH];
  logic [4:0] ld_q [LIST_DEPTH];
  logic [5:0] op_q [LIST_DEPTH];
  logic dn_q [LIST_DEPTH];
  logic ex_q [LIST_DEPTH];
  logic [CW-1:0] cnt_q;

  // latched operation
  logic [2:0] opc_q;
  logic [4:0] pos_q, reg_q;
  logic [PC_WIDTH-1:0] ipc_q;
  logic [4:0] ild_q;
  logic [5:0] iop_q;
  logic idn_q, iex_q, mv_q;

  // result register
  logic [1:0] status_q;
  logic [31:0] rpc_q;
  logic [4:0] rld_q;
  logic [5:0] rop_q;
  logic rdn_q, rex_q, dep_q;

  logic [LIST_DEPTH-1:0] live, pcm, depm, first_pcm;
  logic pos_ok;
  logic [IW-1:0] pidx;

  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      live[i] = (CW'(i) < cnt_q);
      pcm[i]  = live[i] && (pc_q[i] == ipc_q);
      depm[i] = live[i] && (ld_q[i] == reg_q) && !dn_q[i];
    end
    first_pcm = pcm & (~pcm + LIST_DEPTH'(1));
  end
  assign pos_ok = (32'(pos_q) < 32'(cnt_q)) && (32'(pos_q) < LIST_DEPTH);
  assign pidx = IW'(pos_q);
  assign sts_o.busy = 1'b0;
  assign occupancy_o = 6'(cnt_q);

  assign status_o = status_q;
  assign out_pc_o = rpc_q;
  assign out_log_dest_o = rld_q;
  assign out_old_phys_o = rop_q;
  assign out_done_o = rdn_q;
  assign out_exception_o = rex_q;
  assign dependent_o = dep_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      opc_q <= opcode_i; pos_q <= position_i; reg_q <= reg_query_i;
      ipc_q <= entry_pc_i; ild_q <= entry_log_dest_i; iop_q <= entry_old_phys_i;
      idn_q <= entry_done_i; iex_q <= entry_exception_i; mv_q <= mark_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.scan) begin
      if (opc_q == OP_PUSH && cnt_q < CW'(LIST_DEPTH)) cnt_q <= cnt_q + CW'(1);
      else if (opc_q == OP_POP && pos_ok) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      status_q <= ST_OK; dep_q <= 1'b0;
      rpc_q <= '0; rld_q <= '0; rop_q <= '0;
      rdn_q <= 1'b0; rex_q <= 1'b0;
      case (opc_q)
        OP_PUSH: if (cnt_q >= CW'(LIST_DEPTH)) status_q <= ST_FULL;
        OP_PEEK, OP_POP, OP_UPDATE: begin
          if (!pos_ok) status_q <= ST_BADIDX;
          else if (opc_q != OP_UPDATE) begin
            rpc_q <= 32'(pc_q[pidx]); rld_q <= ld_q[pidx];
            rop_q <= op_q[pidx]; rdn_q <= dn_q[pidx];
            rex_q <= ex_q[pidx];
          end
        end
        OP_DEPQ: dep_q <= |depm;
        default: ;
      endcase
    end
  end

  // entry cells
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        case (opc_q)
          OP_PUSH: if (CW'(i) == cnt_q) begin
            pc_q[i] <= ipc_q; ld_q[i] <= ild_q; op_q[i] <= iop_q;
            dn_q[i] <= idn_q; ex_q[i] <= iex_q;
          end
          OP_UPDATE: if (pos_ok && IW'(i) == pidx) begin
            pc_q[i] <= ipc_q; ld_q[i] <= ild_q; op_q[i] <= iop_q;
            dn_q[i] <= idn_q; ex_q[i] <= iex_q;
          end
          OP_POP: if (pos_ok && IW'(i) >= pidx && i < LIST_DEPTH-1) begin
            pc_q[i] <= pc_q[(i+1) % LIST_DEPTH]; ld_q[i] <= ld_q[(i+1) % LIST_DEPTH];
            op_q[i] <= op_q[(i+1) % LIST_DEPTH]; dn_q[i] <= dn_q[(i+1) % LIST_DEPTH];
            ex_q[i] <= ex_q[(i+1) % LIST_DEPTH];
          end
          OP_MDONE: if (first_pcm[i]) dn_q[i] <= mv_q;
          OP_MEXC:  if (first_pcm[i]) ex_q[i] <= mv_q;
          default: ;
        endcase
      end
    end
  end
endmodule

// File: rtl/ral_checker.sv
// Port-level checks for the reorder active list.
// Bound to reorder_active_list_core.
module ral_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status_o,
  input logic [5:0] occupancy_o,
  input logic dependent_o
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status_o))
    else $error("result dropped");
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> occupancy_o <= 6'd32) else $error("occupancy range");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> status_o != 2'd3) else $error("bad status");
endmodule

bind reorder_active_list_core ral_props u_props (.*);
